>>> rtl/core/batch_mean_decimator_four_channel_macros.svh
// assertion macros for the four-channel batch mean decimator
// expects signals clk and rst_n in the scope where a macro is used
`ifndef BATCH_MEAN_DECIMATOR_FOUR_CHANNEL_MACROS_SVH
`define BATCH_MEAN_DECIMATOR_FOUR_CHANNEL_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMD4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BMD4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bmd4_pkg.sv
// shared types and constants of the four-channel batch mean decimator
// no dependencies; imported by every rtl module of the block
package bmd4_pkg;

  localparam int LANES   = 4;
  localparam int SMP_W   = 32;
  localparam int SUM_W   = 38;
  localparam int CNT_W   = 7;
  localparam int DVS_W   = CNT_W + 1;
  localparam int DIV_W   = SUM_W + 1;
  localparam int STEP_W  = $clog2(DIV_W);
  localparam int IN_W    = LANES * SMP_W;
  localparam int OUT_W   = 136;

  // divider sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_DONE
  } div_state_t;

  // controls from sequencer to every lane
  typedef struct packed {
    logic acc;
    logic clear;
    logic prep;
    logic step;
  } lane_ctrl_t;

  // status from sequencer to the merge stage
  typedef struct packed {
    logic             take;
    logic [CNT_W-1:0] count;
  } merge_ctrl_t;

endpackage

>>> rtl/core/bmd4_lane.sv
// one channel lane: batch accumulator and restoring divider for the rounded mean
// depends on bmd4_pkg
module bmd4_lane
  import bmd4_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_ctrl_t              ctl,
  input  logic signed [SMP_W-1:0] sample,
  input  logic [CNT_W-1:0]        count,
  output logic [SMP_W-1:0]        mean
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [DIV_W-1:0] div_r;
  logic [DVS_W-1:0] rem_r;
  logic             neg_r;
  logic [DVS_W-1:0] divisor;
  logic [DVS_W-1:0] trial;
  logic             fits;
  logic [DIV_W-1:0] base;
  logic [DIV_W-1:0] addend;
  logic [SMP_W-1:0] quot;

  // running sum including the request being taken
  assign sum_nxt = sum_r + (ctl.acc ? {{(SUM_W-SMP_W){sample[SMP_W-1]}}, sample}
                                    : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.clear) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_nxt;
    end
  end

  // rounding: quotient of (2*|sum| + n) by 2*n
  assign divisor = {count, 1'b0};
  assign base    = div_r[SUM_W] ? {~div_r[SUM_W-1:0], 1'b0} : {div_r[SUM_W-1:0], 1'b0};
  assign addend  = DIV_W'(count) + (div_r[SUM_W] ? DIV_W'(2) : DIV_W'(0));

  // one quotient bit per step
  assign trial = {rem_r[DVS_W-2:0], div_r[DIV_W-1]};
  assign fits  = (trial >= divisor);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      div_r <= {sum_nxt[SUM_W-1], sum_nxt};
    end else if (ctl.prep) begin
      neg_r <= div_r[SUM_W];
      div_r <= base + addend;
      rem_r <= '0;
    end else if (ctl.step) begin
      rem_r <= fits ? (trial - divisor) : trial;
      div_r <= {div_r[DIV_W-2:0], fits};
    end
  end

  // sign goes back on the rounded magnitude
  assign quot = div_r[SMP_W-1:0];
  assign mean = neg_r ? (SMP_W'(0) - quot) : quot;

endmodule

>>> rtl/core/bmd4_ctrl.sv
// batch counters and divider sequencer shared by all lanes
// depends on bmd4_pkg
module bmd4_ctrl
  import bmd4_pkg::*;
#(
  parameter int BATCH_SIZE = 10
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        sample_valid,
  input  logic        out_free,
  output logic        in_tready,
  output lane_ctrl_t  lane_ctl,
  output merge_ctrl_t merge_ctl
);

  localparam int POS_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  good_r;
  logic [CNT_W-1:0]  good_nxt;
  logic [CNT_W-1:0]  cnt_div_r;
  logic [STEP_W-1:0] step_r;
  div_state_t        state_r;
  div_state_t        state_nxt;
  logic              last;
  logic              accept;
  logic              launch;
  logic              steps_done;

  // a batch-closing request waits until the divider is free
  assign last       = (pos_r == POS_W'(BATCH_SIZE - 1));
  assign in_tready  = !last || (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign good_nxt   = good_r + CNT_W'(sample_valid);
  assign launch     = accept && last && (good_nxt != CNT_W'(0));
  assign steps_done = (step_r == STEP_W'(DIV_W - 1));

  // batch counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      good_r <= '0;
    end else if (accept) begin
      if (last) begin
        pos_r  <= '0;
        good_r <= '0;
      end else begin
        pos_r  <= pos_r + POS_W'(1);
        good_r <= good_nxt;
      end
    end
  end

  // divisor count and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_div_r <= '0;
      step_r    <= '0;
    end else begin
      if (launch) begin
        cnt_div_r <= good_nxt;
      end
      if (state_r == ST_RUN) begin
        step_r <= steps_done ? STEP_W'(0) : step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (launch) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_RUN;
      ST_RUN:  if (steps_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    lane_ctl.acc    = accept && sample_valid;
    lane_ctl.clear  = accept && last;
    lane_ctl.prep   = 1'b0;
    lane_ctl.step   = 1'b0;
    merge_ctl.take  = 1'b0;
    merge_ctl.count = cnt_div_r;
    case (state_r)
      ST_IDLE: ;
      ST_PREP: lane_ctl.prep = 1'b1;
      ST_RUN:  lane_ctl.step = 1'b1;
      ST_DONE: merge_ctl.take = out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/batch_mean_decimator_four_channel.sv
// top level of the four-channel batch mean decimator: lanes, sequencer, output merge
// depends on bmd4_pkg, bmd4_ctrl and bmd4_lane
//
// channel  direction  handshake              payload
// in       slave      in_tvalid/in_tready    in_tuser, in_tdata (128 bits)
// out      master     out_tvalid/out_tready  out_tdata (136 bits)
//
// one request is taken per cycle; a batch-closing request is held off while
// the shared divider sequence of the previous batch is still busy
// after the closing request the lanes take a prepare step, then 39 restoring
// divider steps each, then the result goes into the output register
// reset clears the batch counters, sums and sequencer; out stalls hold the
// result in the output register and then in the lanes
module batch_mean_decimator_four_channel
  import bmd4_pkg::*;
#(
  parameter int BATCH_SIZE = 10
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] heading, [127:96] temperature
  input  logic [IN_W-1:0]  in_tdata,
  // [0] sample_valid
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [31:0] mean_x, [63:32] mean_y, [95:64] mean_heading,
  // [127:96] mean_temperature, [134:128] valid_count, [135] zero
  output logic [OUT_W-1:0] out_tdata
);

  lane_ctrl_t       lane_ctl;
  merge_ctrl_t      merge_ctl;
  logic             out_free;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic [SMP_W-1:0] lane_mean [LANES];

  assign out_free = !out_tvalid_r || out_tready;

  bmd4_ctrl #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .sample_valid (in_tuser),
    .out_free     (out_free),
    .in_tready    (in_tready),
    .lane_ctl     (lane_ctl),
    .merge_ctl    (merge_ctl)
  );

  // one lane per channel
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bmd4_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (in_tdata[g*SMP_W +: SMP_W]),
      .count  (merge_ctl.count),
      .mean   (lane_mean[g])
    );
  end

  // merge lane means and count into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (merge_ctl.take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_ctl.take) begin
      out_tdata_r <= {1'b0, merge_ctl.count, lane_mean[3], lane_mean[2],
                      lane_mean[1], lane_mean[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> rtl/core/bmd4_checker.sv
// port-level checks of the four-channel batch mean decimator, bound to the top level
// depends on bmd4_pkg and batch_mean_decimator_four_channel_macros.svh
`include "batch_mean_decimator_four_channel_macros.svh"

module bmd4_checker
  import bmd4_pkg::*;
#(
  parameter int BATCH_SIZE = 10
)
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  `BMD4_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // a result always has between one and a batch of valid samples
  `BMD4_ASSERT_SAME(a_count_range, out_tvalid, (out_tdata[134:128] != 7'd0) && (out_tdata[134:128] <= 7'(BATCH_SIZE)), "valid_count out of range")

  // the padding bit stays zero
  `BMD4_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[135] == 1'b0, "tdata padding bit set")

endmodule

bind batch_mean_decimator_four_channel bmd4_checker #(
  .BATCH_SIZE (BATCH_SIZE)
) u_bmd4_checker (.*);

>>> dv/batch_mean_decimator_four_channel_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the four-channel batch mean decimator: streams sensor
// requests, predicts each batch mean and checks every result in order
// depends on bmd4_pkg and batch_mean_decimator_four_channel
module batch_mean_decimator_four_channel_tb;
  import bmd4_pkg::*;

  localparam int BATCH     = 10;
  localparam int RAND_BATCHES = 90;
  localparam int TAIL      = 120;     // last requests run with no idling
  localparam int HOLD_AT   = 300;     // accepted requests before the long sink hold
  localparam int HOLD_LEN  = 700;
  localparam int SETTLE    = 60;      // margin above the result latency
  localparam int LIMIT     = 400000;

  // one sensor request and one expected batch mean
  typedef struct packed {
    logic            drain;   // wait for all outstanding means before sending
    logic            ok;
    logic [3:0][31:0] rd;     // x, y, heading, temperature from index 0 up
  } reading_t;

  typedef struct packed {
    logic [6:0]       cnt;
    logic [3:0][31:0] mean;
  } batch_mean_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  reading_t    feed_q[$];
  batch_mean_t pending_means[$];
  string       chan_name [4] = '{"mean_x", "mean_y", "mean_heading", "mean_temperature"};

  int  err_count = 0;
  int  cycle_count = 0;
  int  taken_count = 0;
  int  total_items = 0;
  bit  stim_ready = 1'b0;
  bit  in_taken = 1'b0;

  // predictor state: position in batch, valid samples, per-channel sums
  int unsigned slot_pos = 0;
  int unsigned good_cnt = 0;
  longint      chan_sum [4] = '{0, 0, 0, 0};

  batch_mean_decimator_four_channel #(.BATCH_SIZE(BATCH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // divide rounding to nearest, halves away from zero
  function automatic logic [31:0] rounded_mean(input longint total, input longint n);
    longint mag;
    longint q;
    mag = (total < 0) ? -total : total;
    q = (2 * mag + n) / (2 * n);
    rounded_mean = 32'((total < 0) ? -q : q);
  endfunction

  // fold one accepted request into the batch; queue a mean when a batch closes
  function automatic void fold_sample(input reading_t s);
    batch_mean_t m;
    int c;
    if (s.ok) begin
      for (c = 0; c < 4; c++) chan_sum[c] += longint'($signed(s.rd[c]));
      good_cnt++;
    end
    if (slot_pos + 1 >= BATCH) begin
      if (good_cnt > 0) begin
        for (c = 0; c < 4; c++) m.mean[c] = rounded_mean(chan_sum[c], longint'(good_cnt));
        m.cnt = good_cnt[6:0];
        pending_means = {pending_means, m};
      end
      slot_pos = 0;
      good_cnt = 0;
      for (c = 0; c < 4; c++) chan_sum[c] = 0;
    end else begin
      slot_pos++;
    end
  endfunction

  function automatic bit tail_phase();
    tail_phase = stim_ready && feed_q.size() < TAIL;
  endfunction

  // reading shapes: full range, small for rounding, near max, near min, extremes
  function automatic logic [31:0] pick_reading(input int style);
    case (style)
      1: pick_reading = 32'($urandom_range(0, 16)) - 32'd8;
      2: pick_reading = 32'h7fff_ffff - 32'($urandom_range(0, 1000));
      3: pick_reading = 32'h8000_0000 + 32'($urandom_range(0, 1000));
      4: case ($urandom_range(0, 3))
           0: pick_reading = 32'h7fff_ffff;
           1: pick_reading = 32'h8000_0000;
           2: pick_reading = 32'hffff_ffff;
           default: pick_reading = 32'h0;
         endcase
      default: pick_reading = $urandom;
    endcase
  endfunction

  task automatic add_item(input bit ok, input logic [3:0][31:0] rd, input bit drain);
    reading_t s;
    s.ok = ok;
    s.rd = rd;
    s.drain = drain;
    feed_q = {feed_q, s};
  endtask

  // request driver: holds each request until accepted, idles in bursts
  int send_gap = 0;
  int send_mode = 1;
  always @(negedge clk) begin : feed_driver
    reading_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // request still waiting
    end else if (send_gap > 0) begin
      send_gap--;
      in_tvalid <= 1'b0;
    end else if (feed_q.size() == 0 || (feed_q[0].drain && pending_means.size() != 0)) begin
      in_tvalid <= 1'b0;
    end else if (!tail_phase() && send_mode != 0 &&
                 $urandom_range(0, (send_mode == 1) ? 9 : 2) == 0) begin
      send_gap = $urandom_range(1, 12) - 1;
      in_tvalid <= 1'b0;
    end else begin
      nxt = feed_q[0];
      feed_q.delete(0);
      in_tdata <= nxt.rd;
      in_tuser <= nxt.ok;
      in_tvalid <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) send_mode = $urandom_range(0, 2);
  end

  // result sink: one long hold to back the block up, plus random stall bursts
  int  sink_gap = 0;
  int  sink_mode = 1;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin : result_sink
    if (!hold_done && taken_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_tready <= 1'b0;
    end else if (!tail_phase() && sink_mode != 0 &&
                 $urandom_range(0, (sink_mode == 1) ? 9 : 2) == 0) begin
      sink_gap = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) sink_mode = $urandom_range(0, 2);
  end

  // monitor: predict on accepted requests, check accepted results in order
  always @(posedge clk) begin : stream_monitor
    reading_t    s;
    batch_mean_t m;
    int          c;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        s.drain = 1'b0;
        s.ok = in_tuser;
        s.rd = in_tdata;
        fold_sample(s);
        taken_count++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_means.size() == 0) begin
          $error("result with no mean outstanding: %h", out_tdata);
          err_count++;
        end else begin
          m = pending_means[0];
          pending_means.delete(0);
          for (c = 0; c < 4; c++) begin
            if (out_tdata[c*32 +: 32] !== m.mean[c]) begin
              $error("%s: expected %0d, got %0d", chan_name[c], $signed(m.mean[c]),
                     $signed(out_tdata[c*32 +: 32]));
              err_count++;
            end
          end
          if (out_tdata[134:128] !== m.cnt) begin
            $error("valid_count: expected %0d, got %0d", m.cnt, out_tdata[134:128]);
            err_count++;
          end
          if (out_tdata[135] !== 1'b0) begin
            $error("pad bit: expected 0, got %b", out_tdata[135]);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int b;
    int i;
    int c;
    int vmode;
    int vpct;
    int lone;
    int style [4];
    bit ok;
    logic [3:0][31:0] r;

    // two valid samples among noise: full-scale means and half-way rounding
    for (i = 0; i < BATCH; i++) begin
      if (i == 3)
        add_item(1'b1, {32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff}, 1'b0);
      else if (i == 7)
        add_item(1'b1, {32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff}, 1'b0);
      else
        add_item(1'b0, {4{(i % 2) ? 32'h8000_0000 : 32'h7fff_ffff}}, 1'b0);
    end
    // batch with no valid sample yields nothing
    for (i = 0; i < BATCH; i++) add_item(1'b0, {$urandom, $urandom, $urandom, $urandom}, 1'b0);
    // full batch after a drain: extremes and small values
    for (i = 0; i < BATCH; i++)
      add_item(1'b1, {$urandom, pick_reading(1), 32'h8000_0000, 32'h7fff_ffff}, i == 0);

    // random batches: mostly valid data, some empty, single and sparse batches
    for (b = 0; b < RAND_BATCHES; b++) begin
      vmode = $urandom_range(0, 9);
      vpct = $urandom_range(20, 90);
      lone = $urandom_range(0, BATCH - 1);
      for (c = 0; c < 4; c++) style[c] = $urandom_range(0, 4);
      for (i = 0; i < BATCH; i++) begin
        if (vmode == 0) ok = 1'b0;
        else if (vmode == 1) ok = (i == lone);
        else if (vmode <= 5) ok = 1'b1;
        else ok = ($urandom_range(0, 99) < vpct);
        for (c = 0; c < 4; c++) r[c] = pick_reading(style[c]);
        add_item(ok, r, (b == 45 && i == 0));
      end
    end
    total_items = feed_q.size();
    stim_ready = 1'b1;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    while (taken_count < total_items) @(negedge clk);
    while (pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
